>>> hdl/its_pkg.sv
// constants and types shared by the intercept time solver
package its_pkg;

  localparam int unsigned DelW  = 33;
  localparam int unsigned VelW  = 32;
  localparam int unsigned AW    = 66;
  localparam int unsigned BW    = 67;
  localparam int unsigned CW    = 68;
  localparam int unsigned MagW  = 69;
  localparam int unsigned LimbW = 23;
  localparam int unsigned NLimb = 3;
  localparam int unsigned PpW   = 2 * LimbW;
  localparam int unsigned DW    = 138;
  localparam int unsigned FW    = 136;
  localparam int unsigned PW    = 100;
  localparam int unsigned GW    = 102;
  localparam int unsigned TW    = 32;
  localparam int unsigned NBit  = 32;
  localparam int unsigned SpdW  = 31;

  typedef struct packed {
    logic valid;
    logic search;
  } its_meta_t;

endpackage

>>> hdl/intercept_time_solver.sv
// intercept time solver: pipelined constant-speed intercept time
// One request is taken per clock while the input side is not stopped (s_tready_o high): seven front stages form
// the relative position, the quadratic coefficients and the discriminant sign (with the wide
// products split into 23-bit limbs), then a 32-stage bit-by-bit search settles one bit of the
// Q16.16 time per stage by incremental update of the quadratic, then an output register. A
// second output register absorbs one result while the downstream side stalls, so the input side
// stops only once both hold a result. The time is floored, saturates at all ones and is zero
// when no intercept exists (tuser low).
module intercept_time_solver (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [30:0]  cfg_wdata_i,   // max_speed
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  // obj_pos_x, obj_pos_y, obj_pos_z, obj_vel_x, obj_vel_y, obj_vel_z,
  // robot_pos_x, robot_pos_y, robot_pos_z
  input  logic [287:0] s_tdata_i,
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  output logic [31:0]  m_tdata_o,     // intercept_time
  output logic         m_tuser_o      // time_valid
);

  localparam int unsigned NS = its_pkg::NBit;

  logic [its_pkg::SpdW-1:0] max_speed_q;
  logic en;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic sv_q [0:NS];

  logic signed [its_pkg::DelW-1:0] del_q [0:2];
  logic signed [its_pkg::VelW-1:0] vel_q [0:2];
  logic signed [63:0] vv_q [0:2];
  logic signed [64:0] dv_q [0:2];
  logic signed [65:0] dd_q [0:2];
  logic [61:0] ms2_q;
  logic signed [its_pkg::AW-1:0] a3_q, a4_q, a5_q, a6_q;
  logic signed [its_pkg::BW-1:0] b3_q, b4_q, b5_q, b6_q;
  logic signed [its_pkg::CW-1:0] c3_q, c4_q, c5_q, c6_q;
  logic [its_pkg::MagW-1:0] am_q, bm_q, cm_q;
  logic [its_pkg::PpW-1:0] pb_q [0:8];
  logic [its_pkg::PpW-1:0] pa_q [0:8];
  logic [its_pkg::DW-1:0] bsq_q, ac_q;
  logic [its_pkg::DW-1:0] bsq_d, ac_d;

  logic signed [its_pkg::FW-1:0] f_q [0:NS];
  logic signed [its_pkg::PW-1:0] p_q [0:NS-1];
  logic [its_pkg::TW-1:0] t_q [0:NS];
  logic signed [its_pkg::AW-1:0] sa_q [0:NS-1];
  logic signed [its_pkg::BW-1:0] sb_q [0:NS-1];
  logic apos_q [0:NS-1];
  its_pkg::its_meta_t meta_q [0:NS];
  its_pkg::its_meta_t meta_d;

  logic out_v_q, skid_v_q, out_flag_q, skid_flag_q;
  logic [its_pkg::TW-1:0] out_time_q, skid_time_q;
  logic inc_v, inc_flag, take;
  logic [its_pkg::TW-1:0] inc_time;

  assign en         = !skid_v_q;
  assign s_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q <= its_pkg::SpdW'(65536);
    end else if (cfg_we_i) begin
      max_speed_q <= cfg_wdata_i;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      for (int i = 0; i <= NS; i++) sv_q[i] <= 1'b0;
    end else if (en) begin
      v1_q <= s_tvalid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      sv_q[0] <= v6_q;
      for (int i = 0; i < NS; i++) sv_q[i+1] <= sv_q[i];
    end
  end

  // front stages: deltas, products, coefficients, magnitudes
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        del_q[i] <= $signed({s_tdata_i[32*i+31], s_tdata_i[32*i +: 32]})
                  - $signed({s_tdata_i[32*(6+i)+31], s_tdata_i[32*(6+i) +: 32]});
        vel_q[i] <= $signed(s_tdata_i[32*(3+i) +: 32]);
        vv_q[i]  <= 64'(vel_q[i]) * 64'(vel_q[i]);
        dv_q[i]  <= 65'(del_q[i]) * 65'(vel_q[i]);
        dd_q[i]  <= 66'(del_q[i]) * 66'(del_q[i]);
      end
      ms2_q <= 62'(max_speed_q) * 62'(max_speed_q);
      a3_q  <= its_pkg::AW'(vv_q[0]) + its_pkg::AW'(vv_q[1]) + its_pkg::AW'(vv_q[2])
             - $signed(its_pkg::AW'(ms2_q));
      b3_q  <= (its_pkg::BW'(dv_q[0]) + its_pkg::BW'(dv_q[1]) + its_pkg::BW'(dv_q[2])) <<< 1;
      c3_q  <= its_pkg::CW'(dd_q[0]) + its_pkg::CW'(dd_q[1]) + its_pkg::CW'(dd_q[2]);
      a4_q  <= a3_q;
      b4_q  <= b3_q;
      c4_q  <= c3_q;
      am_q  <= its_pkg::MagW'(a3_q[its_pkg::AW-1] ? -a3_q : a3_q);
      bm_q  <= its_pkg::MagW'(b3_q[its_pkg::BW-1] ? -b3_q : b3_q);
      cm_q  <= its_pkg::MagW'(c3_q);
      for (int i = 0; i < its_pkg::NLimb; i++) begin
        for (int j = 0; j < its_pkg::NLimb; j++) begin
          pb_q[3*i+j] <= its_pkg::PpW'(bm_q[its_pkg::LimbW*i +: its_pkg::LimbW])
                       * its_pkg::PpW'(bm_q[its_pkg::LimbW*j +: its_pkg::LimbW]);
          pa_q[3*i+j] <= its_pkg::PpW'(am_q[its_pkg::LimbW*i +: its_pkg::LimbW])
                       * its_pkg::PpW'(cm_q[its_pkg::LimbW*j +: its_pkg::LimbW]);
        end
      end
      a5_q  <= a4_q;
      b5_q  <= b4_q;
      c5_q  <= c4_q;
      bsq_q <= bsq_d;
      ac_q  <= ac_d;
      a6_q  <= a5_q;
      b6_q  <= b5_q;
      c6_q  <= c5_q;
    end
  end

  // partial products grouped into non-overlapping rows, then a shallow adder tree
  always_comb begin
    bsq_d = ((its_pkg::DW'({pb_q[8], pb_q[4], pb_q[0]})
            + (its_pkg::DW'({pb_q[5], pb_q[1]}) << its_pkg::LimbW))
           + ((its_pkg::DW'({pb_q[7], pb_q[3]}) << its_pkg::LimbW)
            + (its_pkg::DW'(pb_q[2]) << (2 * its_pkg::LimbW))))
          + (its_pkg::DW'(pb_q[6]) << (2 * its_pkg::LimbW));
    ac_d  = ((its_pkg::DW'({pa_q[8], pa_q[4], pa_q[0]})
            + (its_pkg::DW'({pa_q[5], pa_q[1]}) << its_pkg::LimbW))
           + ((its_pkg::DW'({pa_q[7], pa_q[3]}) << its_pkg::LimbW)
            + (its_pkg::DW'(pa_q[2]) << (2 * its_pkg::LimbW))))
          + (its_pkg::DW'(pa_q[6]) << (2 * its_pkg::LimbW));
  end

  // case decision from the signs of the coefficients and of the discriminant
  always_comb begin
    logic an, az, bn, bz, cz, dneg;
    an   = a6_q[its_pkg::AW-1];
    az   = (a6_q == '0);
    bn   = b6_q[its_pkg::BW-1];
    bz   = (b6_q == '0);
    cz   = (c6_q == '0);
    dneg = (bsq_q < (ac_q << 2));
    meta_d = '0;
    if (az) begin
      if (bn) begin
        meta_d.valid  = 1'b1;
        meta_d.search = 1'b1;
      end else if (!bz) begin
        meta_d.valid = cz;
      end
    end else if (an) begin
      meta_d.valid  = 1'b1;
      meta_d.search = !cz || bn;
    end else if (!dneg) begin
      if (cz) begin
        meta_d.valid = 1'b1;
      end else if (bn) begin
        meta_d.valid  = 1'b1;
        meta_d.search = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      meta_q[0] <= meta_d;
      f_q[0]    <= its_pkg::FW'(c6_q) <<< 32;
      p_q[0]    <= '0;
      t_q[0]    <= '0;
      sa_q[0]   <= a6_q;
      sb_q[0]   <= b6_q;
      apos_q[0] <= !a6_q[its_pkg::AW-1] && (a6_q != '0);
    end
  end

  // one time bit per stage, most significant first
  for (genvar i = 0; i < NS; i++) begin : g_bit
    localparam int unsigned K = NS - 1 - i;
    logic signed [its_pkg::FW-1:0] cf;
    logic signed [its_pkg::PW-1:0] cp;
    logic signed [its_pkg::GW-1:0] g;
    logic ok;

    always_comb begin
      cf = f_q[i] + (its_pkg::FW'(p_q[i]) <<< (K+1)) + (its_pkg::FW'(sa_q[i]) <<< (2*K))
         + (its_pkg::FW'(sb_q[i]) <<< (K+16));
      cp = p_q[i] + (its_pkg::PW'(sa_q[i]) <<< K);
      g  = (its_pkg::GW'(cp) <<< 1) + (its_pkg::GW'(sb_q[i]) <<< 16);
      ok = !cf[its_pkg::FW-1] && !(apos_q[i] && !g[its_pkg::GW-1] && (g != '0));
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        f_q[i+1]    <= ok ? cf : f_q[i];
        t_q[i+1]    <= ok ? (t_q[i] | (its_pkg::TW'(1) << K)) : t_q[i];
        meta_q[i+1] <= meta_q[i];
      end
    end

    if (i < NS - 1) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (en) begin
          p_q[i+1]    <= ok ? cp : p_q[i];
          sa_q[i+1]   <= sa_q[i];
          sb_q[i+1]   <= sb_q[i];
          apos_q[i+1] <= apos_q[i];
        end
      end
    end
  end

  // output register and skid register
  assign inc_v    = en && sv_q[NS];
  assign inc_flag = meta_q[NS].valid;
  assign inc_time = (meta_q[NS].valid && meta_q[NS].search) ? t_q[NS] : '0;
  assign take     = out_v_q && m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (!out_v_q || take) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end
    end else if (!out_v_q || take) begin
      out_v_q <= inc_v;
    end else if (inc_v) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (!out_v_q || take) begin
        out_flag_q <= skid_flag_q;
        out_time_q <= skid_time_q;
      end
    end else if (!out_v_q || take) begin
      out_flag_q <= inc_flag;
      out_time_q <= inc_time;
    end else begin
      skid_flag_q <= inc_flag;
      skid_time_q <= inc_time;
    end
  end

  assign m_tvalid_o = out_v_q;
  assign m_tdata_o  = out_time_q;
  assign m_tuser_o  = out_flag_q;

`ifndef ASSERT_OFF
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tuser_o |-> m_tdata_o == '0)
    else $error("invalid result carries a nonzero time");

  a_skid_only_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register full while output register empty");

  a_skid_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !m_tready_i |=> skid_v_q && !s_tready_o)
    else $error("skid register lost a result under stall");

  a_search_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q[NS] |-> !f_q[NS][its_pkg::FW-1])
    else $error("search kept a point beyond the root");
`endif

endmodule
